// File: design/cpu16_pkg.sv
// Shared types and constants of the 16-bit CPU core.
package cpu16_pkg;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] load_offset;
    logic [7:0]  byte_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  out_kind;
    logic [7:0]  out_char;
    logic [15:0] pc_now;
    logic [15:0] psw_now;
  } out_t;

  // item functions
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_EXEC = 2'd1;
  localparam logic [1:0] FUNC_KEY  = 2'd2;
  localparam logic [1:0] FUNC_TICK = 2'd3;

  // run status
  localparam logic [1:0] RUN_OK    = 2'd0;
  localparam logic [1:0] RUN_DONE  = 2'd1;
  localparam logic [1:0] RUN_FAULT = 2'd2;
  localparam logic [1:0] RUN_KEY   = 2'd3;

  // print kinds
  localparam logic [1:0] OUT_NONE = 2'd0;
  localparam logic [1:0] OUT_CHAR = 2'd1;
  localparam logic [1:0] OUT_CRLF = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_SIZE  = 2'd1;
  localparam logic [1:0] CFG_START = 2'd2;

  // operations
  localparam logic [3:0] OP_ADD  = 4'd0;
  localparam logic [3:0] OP_SUB  = 4'd1;
  localparam logic [3:0] OP_MUL  = 4'd2;
  localparam logic [3:0] OP_DIV  = 4'd3;
  localparam logic [3:0] OP_CMP  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_OR   = 4'd6;
  localparam logic [3:0] OP_NOT  = 4'd7;
  localparam logic [3:0] OP_TEST = 4'd8;
  localparam logic [3:0] OP_PUSH = 4'd9;
  localparam logic [3:0] OP_POP  = 4'd10;
  localparam logic [3:0] OP_CALL = 4'd11;
  localparam logic [3:0] OP_IRET = 4'd12;
  localparam logic [3:0] OP_MOV  = 4'd13;
  localparam logic [3:0] OP_SHL  = 4'd14;
  localparam logic [3:0] OP_SHR  = 4'd15;

  // operand kinds
  localparam logic [1:0] KIND_IMM = 2'd0;
  localparam logic [1:0] KIND_REG = 2'd1;
  localparam logic [1:0] KIND_ABS = 2'd2;
  localparam logic [1:0] KIND_IDX = 2'd3;

  // conditions
  localparam logic [1:0] CC_Z   = 2'd0;
  localparam logic [1:0] CC_NZ  = 2'd1;
  localparam logic [1:0] CC_GT  = 2'd2;
  localparam logic [1:0] CC_ALL = 2'd3;

  localparam logic [15:0] KEY_ADDR     = 16'hFFFC;
  localparam logic [15:0] PUT_ADDR     = 16'hFFFE;
  localparam logic [15:0] DFLT_VEC     = 16'h0080;
  localparam logic [15:0] DFLT_VAL     = 16'h00F0;
  localparam logic [15:0] PSW_INIT     = 16'hA000;
  localparam logic [15:0] NEWLINE_CODE = 16'h0010;
  localparam logic [15:0] VEC_END      = 16'h0010;
  localparam int unsigned IRQ_ON_BIT   = 15;
  localparam int unsigned TICK_ON_BIT  = 13;
  localparam logic [7:0]  KEY_STOP     = 8'd3;
  localparam logic [2:0]  R_SP         = 3'd6;
  localparam logic [2:0]  R_PC         = 3'd7;

endpackage

// File: design/cpu16_ram.sv
// Generic single-port synchronous RAM with registered read.
module cpu16_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/cpu16_div.sv
// Restoring 16-bit divider, one quotient bit per cycle.
module cpu16_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [15:0] quot_o
);

  logic [15:0] quo_q, rem_q, dvs_q;
  logic [3:0]  cnt_q;
  logic        busy_q, done_q;
  logic [16:0] rem2;
  logic        ge;

  assign rem2 = {rem_q, quo_q[15]};
  assign ge   = rem2 >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q <= dividend_i;
        rem_q <= '0;
        dvs_q <= divisor_i;
        cnt_q <= '0;
        if (divisor_i == 16'd0) begin
          // divide by zero saturates
          quo_q  <= 16'hFFFF;
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        quo_q <= {quo_q[14:0], ge};
        rem_q <= ge ? 16'(rem2 - {1'b0, dvs_q}) : rem2[15:0];
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: design/sixteen_bit_cpu_core_unit.sv
// Top level: instruction sequencer of the 16-bit CPU core around image and stack RAMs.
// Load, key and tick words go from acceptance to the response state, which registers
// the result once the output register is free. In execute words each image word access
// goes over the single image RAM port, a divide waits for the divider, and each taken
// interrupt pushes the PSW and PC onto the stack. One word is worked on at a time.
// After reset both RAMs are zeroed before any input is accepted.
module sixteen_bit_cpu_core_unit #(
  parameter int unsigned MEM_BYTES   = 4096,
  parameter int unsigned STACK_BYTES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cpu16_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cpu16_pkg::out_t   out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);
  import cpu16_pkg::*;

  localparam int unsigned MW    = $clog2(MEM_BYTES);
  localparam int unsigned SW    = $clog2(STACK_BYTES);
  localparam int unsigned CLR_N = (MEM_BYTES > STACK_BYTES) ? MEM_BYTES : STACK_BYTES;
  localparam int unsigned CLW   = $clog2(CLR_N);
  localparam logic [16:0] MEM17 = 17'(MEM_BYTES);
  localparam logic [16:0] STK17 = 17'(STACK_BYTES);
  localparam logic [CLW:0] CLR_MEM = (CLW+1)'(MEM_BYTES);
  localparam logic [CLW:0] CLR_STK = (CLW+1)'(STACK_BYTES);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_START, S_IRQ, S_IRQ_PC, S_IRQ_VEC, S_DECODE, S_EXT, S_COND,
    S_SRC, S_SRC_DONE, S_DST, S_DST_DONE, S_EXEC, S_DIV, S_STORE, S_FLAGS, S_CALL,
    S_POP_DONE, S_IRET_PC, S_IRET_PSW, S_RD0, S_RD1, S_RD2, S_WR0, S_WR1,
    S_PUSH_HI, S_PUSH_LO, S_POP_A, S_POP_B, S_RESP
  } state_e;

  state_e      state_q, ret_q;
  logic [CLW-1:0] clr_q;
  logic [15:0] regs_q [8];
  logic [15:0] vec_q [8];
  logic [7:0]  pend_q;
  logic [15:0] psw_q, depth_q, base_q, start_q;
  logic [12:0] size_q;
  logic [7:0]  key_q, char_q;
  logic [1:0]  run_q, kind_q;
  logic        started_q, pop_hi_q, pop_rd_q;
  logic [3:0]  k_q;
  logic [15:0] ir_q, ext_q, sv_q, dv_q, res_q, word_q, addr_q, push_q;
  logic [3:0]  fl_mask_q, fl_val_q;
  logic [MW-1:0] off_q;
  logic        out_valid_q;
  out_t        out_q;

  // instruction fields
  logic [1:0] cc, dk, sk;
  logic [3:0] op;
  logic [2:0] dr, sr;
  assign cc = ir_q[15:14];
  assign op = ir_q[13:10];
  assign dk = ir_q[9:8];
  assign dr = ir_q[7:5];
  assign sk = ir_q[4:3];
  assign sr = ir_q[2:0];

  logic [15:0] swapped;
  logic [3:0]  n_op;
  logic        n_no_d, n_no_s, n_ext;
  assign swapped = {word_q[7:0], word_q[15:8]};
  assign n_op    = swapped[13:10];
  assign n_no_d  = (n_op == OP_PUSH) || (n_op == OP_CALL) || (n_op == OP_IRET);
  assign n_no_s  = (n_op == OP_POP) || (n_op == OP_IRET);
  assign n_ext   = (!n_no_d && swapped[9:8] != KIND_REG) ||
                   (!n_no_s && swapped[4:3] != KIND_REG);

  logic no_d, no_s;
  assign no_d = (op == OP_PUSH) || (op == OP_CALL) || (op == OP_IRET);
  assign no_s = (op == OP_POP) || (op == OP_IRET);

  // register file and vector read ports
  logic [2:0]  rf_idx, vec_idx;
  logic [15:0] rf_rd, vec_rd, sp, pc, sp_m1;
  assign rf_idx  = (state_q == S_SRC) ? sr : dr;
  assign rf_rd   = regs_q[rf_idx];
  assign vec_idx = (state_q == S_RD0) ? addr_q[3:1] : k_q[2:0];
  assign vec_rd  = vec_q[vec_idx];
  assign sp      = regs_q[R_SP];
  assign pc      = regs_q[R_PC];
  assign sp_m1   = sp - 16'd1;

  // image address check
  logic [16:0] off17, lim17, size17;
  logic        bad, lt16, sp_ok;
  assign size17 = {4'd0, size_q};
  assign lim17  = (size17 < MEM17) ? size17 : MEM17;
  assign off17  = {1'b0, addr_q} - {1'b0, base_q};
  assign bad    = (addr_q < base_q) || ((off17 + 17'd1) >= lim17);
  assign lt16   = addr_q < VEC_END;
  assign sp_ok  = {1'b0, sp} < STK17;

  // handshake
  logic in_fire, ld_ok;
  logic [16:0] ld17;
  assign in_stall_o  = state_q != S_IDLE;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign ld17        = {5'd0, in_data_i.load_offset};
  assign ld_ok       = ld17 < MEM17;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ALU
  logic [31:0] prod, sh32;
  logic [16:0] sum17;
  logic [15:0] alu_res;
  logic        alu_c;
  assign prod  = dv_q * sv_q;
  assign sh32  = {16'd0, dv_q} << sv_q[4:0];
  assign sum17 = {1'b0, dv_q} + {1'b0, sv_q};

  always_comb begin
    alu_res = '0;
    alu_c   = 1'b0;
    unique case (op)
      OP_ADD: begin
        alu_res = sum17[15:0];
        alu_c   = sum17[16];
      end
      OP_SUB, OP_CMP: begin
        alu_res = dv_q - sv_q;
        alu_c   = dv_q < sv_q;
      end
      OP_MUL:  alu_res = prod[15:0];
      OP_AND:  alu_res = dv_q & sv_q;
      OP_OR:   alu_res = dv_q | sv_q;
      OP_NOT:  alu_res = ~sv_q;
      OP_TEST: alu_res = dv_q & sv_q;
      OP_MOV:  alu_res = sv_q;
      OP_SHL: begin
        if (sv_q < 16'd32) begin
          alu_res = sh32[15:0];
          alu_c   = sh32[16];
        end
      end
      OP_SHR: begin
        if (sv_q < 16'd16) begin
          alu_res = dv_q >> sv_q[3:0];
        end
      end
      default: ;
    endcase
  end

  // divider
  logic        div_start, div_done;
  logic [15:0] div_quot;
  assign div_start = (state_q == S_EXEC) && (op == OP_DIV);

  cpu16_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dv_q),
    .divisor_i  (sv_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // RAM ports
  logic          img_we, stk_we;
  logic [MW-1:0] img_addr;
  logic [SW-1:0] stk_addr;
  logic [7:0]    img_wdata, stk_wdata, img_rdata, stk_rdata;

  always_comb begin
    img_we    = 1'b0;
    img_addr  = off17[MW-1:0];
    img_wdata = '0;
    stk_we    = 1'b0;
    stk_addr  = sp[SW-1:0];
    stk_wdata = '0;
    unique case (state_q)
      S_CLEAR: begin
        img_we   = {1'b0, clr_q} < CLR_MEM;
        img_addr = clr_q[MW-1:0];
        stk_we   = {1'b0, clr_q} < CLR_STK;
        stk_addr = clr_q[SW-1:0];
      end
      S_IDLE: begin
        img_we    = in_fire && (in_data_i.func == FUNC_LOAD) && ld_ok;
        img_addr  = ld17[MW-1:0];
        img_wdata = in_data_i.byte_value;
      end
      S_RD1: img_addr = off_q + 1'b1;
      S_WR0: begin
        img_we    = !(addr_q == KEY_ADDR || addr_q == PUT_ADDR || lt16 || bad);
        img_wdata = res_q[7:0];
      end
      S_WR1: begin
        img_we    = 1'b1;
        img_addr  = off_q + 1'b1;
        img_wdata = res_q[15:8];
      end
      S_PUSH_HI: begin
        stk_we    = sp_ok;
        stk_wdata = push_q[15:8];
      end
      S_PUSH_LO: begin
        stk_we    = sp_ok;
        stk_wdata = push_q[7:0];
      end
      S_POP_A: stk_addr = sp_m1[SW-1:0];
      default: ;
    endcase
  end

  cpu16_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_img (
    .clk_i   (clk_i),
    .we_i    (img_we),
    .addr_i  (img_addr),
    .wdata_i (img_wdata),
    .rdata_o (img_rdata)
  );

  cpu16_ram #(.WIDTH(8), .DEPTH(STACK_BYTES)) u_stk (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .addr_i  (stk_addr),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rdata)
  );

  logic go, irq_take;
  logic [7:0] pop_byte;
  always_comb begin
    unique case (cc)
      CC_Z:    go = psw_q[0];
      CC_NZ:   go = !psw_q[0];
      CC_GT:   go = !psw_q[0] && !psw_q[3];
      default: go = 1'b1;
    endcase
  end
  assign irq_take = psw_q[IRQ_ON_BIT] && pend_q[k_q[2:0]] &&
                    !(k_q[2:0] == 3'd1 && !psw_q[TICK_ON_BIT]);
  assign pop_byte = pop_rd_q ? stk_rdata : 8'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ret_q       <= S_IDLE;
      clr_q       <= '0;
      for (int i = 0; i < 8; i++) begin
        regs_q[i] <= '0;
        vec_q[i]  <= DFLT_VEC;
      end
      pend_q      <= 8'd1;
      psw_q       <= PSW_INIT;
      depth_q     <= '0;
      base_q      <= '0;
      size_q      <= '0;
      start_q     <= '0;
      key_q       <= '0;
      run_q       <= RUN_OK;
      started_q   <= 1'b0;
      kind_q      <= OUT_NONE;
      char_q      <= '0;
      k_q         <= '0;
      pop_hi_q    <= 1'b0;
      pop_rd_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CLW'(CLR_N - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            kind_q  <= OUT_NONE;
            char_q  <= '0;
            state_q <= S_RESP;
            if (in_data_i.func != FUNC_LOAD && run_q == RUN_OK) begin
              unique case (in_data_i.func)
                FUNC_EXEC: state_q <= S_START;
                FUNC_KEY: begin
                  key_q <= in_data_i.byte_value;
                  if (in_data_i.byte_value == KEY_STOP) begin
                    run_q <= RUN_KEY;
                  end else begin
                    pend_q[2] <= 1'b1;
                  end
                end
                default: pend_q[1] <= 1'b1;
              endcase
            end
          end
        end
        S_START: begin
          k_q     <= '0;
          state_q <= S_IRQ;
          if (!started_q) begin
            started_q    <= 1'b1;
            regs_q[R_PC] <= start_q;
            if (start_q == 16'd0) begin
              run_q   <= RUN_FAULT;
              state_q <= S_RESP;
            end
          end
        end
        S_IRQ: begin
          if (k_q[3]) begin
            addr_q  <= pc;
            ret_q   <= S_DECODE;
            state_q <= S_RD0;
          end else if (irq_take) begin
            push_q  <= psw_q;
            ret_q   <= S_IRQ_PC;
            state_q <= S_PUSH_HI;
          end else begin
            k_q <= k_q + 4'd1;
          end
        end
        S_IRQ_PC: begin
          push_q  <= pc;
          ret_q   <= S_IRQ_VEC;
          state_q <= S_PUSH_HI;
        end
        S_IRQ_VEC: begin
          regs_q[R_PC]     <= vec_rd;
          pend_q[k_q[2:0]] <= 1'b0;
          k_q              <= k_q + 4'd1;
          state_q          <= S_IRQ;
        end
        S_DECODE: begin
          ir_q         <= swapped;
          regs_q[R_PC] <= pc + 16'd2;
          if (n_ext) begin
            addr_q  <= pc + 16'd2;
            ret_q   <= S_EXT;
            state_q <= S_RD0;
          end else begin
            state_q <= S_COND;
          end
        end
        S_EXT: begin
          ext_q        <= word_q;
          regs_q[R_PC] <= pc + 16'd2;
          state_q      <= S_COND;
        end
        S_COND: begin
          if (!go) begin
            state_q <= S_RESP;
          end else if (!no_s) begin
            state_q <= S_SRC;
          end else if (!no_d) begin
            state_q <= S_DST;
          end else begin
            state_q <= S_EXEC;
          end
        end
        S_SRC: begin
          state_q <= no_d ? S_EXEC : S_DST;
          unique case (sk)
            KIND_IMM: sv_q <= (sr == 3'd7) ? psw_q : ext_q;
            KIND_REG: sv_q <= rf_rd;
            KIND_ABS: begin
              addr_q  <= ext_q;
              ret_q   <= S_SRC_DONE;
              state_q <= S_RD0;
            end
            default: begin
              addr_q  <= rf_rd + ext_q;
              ret_q   <= S_SRC_DONE;
              state_q <= S_RD0;
            end
          endcase
        end
        S_SRC_DONE: begin
          sv_q    <= word_q;
          state_q <= no_d ? S_EXEC : S_DST;
        end
        S_DST: begin
          state_q <= S_EXEC;
          unique case (dk)
            KIND_IMM: dv_q <= psw_q;
            KIND_REG: dv_q <= rf_rd;
            KIND_ABS: begin
              addr_q  <= ext_q;
              ret_q   <= S_DST_DONE;
              state_q <= S_RD0;
            end
            default: begin
              addr_q  <= rf_rd + ext_q;
              ret_q   <= S_DST_DONE;
              state_q <= S_RD0;
            end
          endcase
        end
        S_DST_DONE: begin
          dv_q    <= word_q;
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          res_q     <= alu_res;
          fl_val_q  <= {alu_res[15], alu_c, alu_c, alu_res == 16'd0};
          fl_mask_q <= 4'b1001;
          state_q   <= S_STORE;
          unique case (op)
            OP_ADD, OP_SUB: fl_mask_q <= 4'b1111;
            OP_CMP: begin
              fl_mask_q <= 4'b1111;
              state_q   <= S_FLAGS;
            end
            OP_TEST: state_q <= S_FLAGS;
            OP_SHL, OP_SHR: fl_mask_q <= 4'b1101;
            OP_DIV: state_q <= S_DIV;
            OP_PUSH: begin
              push_q  <= sv_q;
              ret_q   <= S_RESP;
              state_q <= S_PUSH_HI;
            end
            OP_POP: begin
              fl_mask_q <= 4'b0000;
              pop_hi_q  <= 1'b0;
              ret_q     <= S_POP_DONE;
              state_q   <= S_POP_A;
              // return from the top level ends the run
              if (dk == KIND_REG && dr == R_PC) begin
                if (depth_q == 16'd0) begin
                  run_q   <= RUN_DONE;
                  state_q <= S_RESP;
                end else begin
                  depth_q <= depth_q - 16'd1;
                end
              end
            end
            OP_CALL: begin
              depth_q <= depth_q + 16'd1;
              push_q  <= pc;
              ret_q   <= S_CALL;
              state_q <= S_PUSH_HI;
            end
            OP_IRET: begin
              pop_hi_q <= 1'b0;
              ret_q    <= S_IRET_PC;
              state_q  <= S_POP_A;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            res_q     <= div_quot;
            fl_val_q  <= {div_quot[15], 2'b00, div_quot == 16'd0};
            fl_mask_q <= 4'b1001;
            state_q   <= S_STORE;
          end
        end
        S_STORE: begin
          state_q <= S_FLAGS;
          unique case (dk)
            KIND_IMM: psw_q      <= res_q;
            KIND_REG: regs_q[dr] <= res_q;
            KIND_ABS: begin
              addr_q  <= ext_q;
              ret_q   <= S_FLAGS;
              state_q <= S_WR0;
            end
            default: begin
              addr_q  <= rf_rd + ext_q;
              ret_q   <= S_FLAGS;
              state_q <= S_WR0;
            end
          endcase
        end
        S_FLAGS: begin
          psw_q[3:0] <= (psw_q[3:0] & ~fl_mask_q) | (fl_val_q & fl_mask_q);
          state_q    <= S_RESP;
        end
        S_CALL: begin
          regs_q[R_PC] <= sv_q;
          state_q      <= S_RESP;
        end
        S_POP_DONE: begin
          res_q   <= word_q;
          state_q <= S_STORE;
        end
        S_IRET_PC: begin
          regs_q[R_PC] <= word_q;
          pop_hi_q     <= 1'b0;
          ret_q        <= S_IRET_PSW;
          state_q      <= S_POP_A;
        end
        S_IRET_PSW: begin
          psw_q   <= word_q;
          state_q <= S_RESP;
        end
        S_RD0: begin
          state_q <= ret_q;
          if (addr_q == KEY_ADDR) begin
            word_q <= {8'd0, key_q};
          end else if (addr_q == PUT_ADDR) begin
            word_q <= '0;
          end else if (addr_q == DFLT_VEC) begin
            word_q <= DFLT_VAL;
          end else if (lt16) begin
            word_q <= vec_rd;
          end else if (bad) begin
            run_q   <= RUN_FAULT;
            state_q <= S_RESP;
          end else begin
            off_q   <= off17[MW-1:0];
            state_q <= S_RD1;
          end
        end
        S_RD1: begin
          word_q[7:0] <= img_rdata;
          state_q     <= S_RD2;
        end
        S_RD2: begin
          word_q[15:8] <= img_rdata;
          state_q      <= ret_q;
        end
        S_WR0: begin
          state_q <= ret_q;
          if (addr_q == KEY_ADDR) begin
            // key register is read only
          end else if (addr_q == PUT_ADDR) begin
            if (res_q == NEWLINE_CODE) begin
              kind_q <= OUT_CRLF;
              char_q <= '0;
            end else begin
              kind_q <= OUT_CHAR;
              char_q <= res_q[7:0];
            end
          end else if (lt16) begin
            vec_q[addr_q[3:1]] <= res_q;
          end else if (bad) begin
            run_q   <= RUN_FAULT;
            state_q <= S_RESP;
          end else begin
            off_q   <= off17[MW-1:0];
            state_q <= S_WR1;
          end
        end
        S_WR1: state_q <= ret_q;
        S_PUSH_HI: begin
          if (sp_ok) begin
            regs_q[R_SP] <= sp + 16'd1;
          end
          state_q <= S_PUSH_LO;
        end
        S_PUSH_LO: begin
          if (sp_ok) begin
            regs_q[R_SP] <= sp + 16'd1;
          end
          state_q <= ret_q;
        end
        S_POP_A: begin
          pop_rd_q <= 1'b0;
          if (sp != 16'd0) begin
            regs_q[R_SP] <= sp_m1;
            pop_rd_q     <= {1'b0, sp_m1} < STK17;
          end
          state_q <= S_POP_B;
        end
        S_POP_B: begin
          if (!pop_hi_q) begin
            word_q[7:0] <= pop_byte;
            pop_hi_q    <= 1'b1;
            state_q     <= S_POP_A;
          end else begin
            word_q[15:8] <= pop_byte;
            state_q      <= ret_q;
          end
        end
        S_RESP: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q      <= 1'b1;
            out_q.status     <= run_q;
            out_q.out_kind   <= kind_q;
            out_q.out_char   <= char_q;
            out_q.pc_now     <= pc;
            out_q.psw_now    <= psw_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_BASE: base_q <= cfg_data_i;
          CFG_SIZE: size_q <= cfg_data_i[12:0];
          CFG_START: begin
            start_q <= cfg_data_i;
            if (!started_q) begin
              regs_q[R_PC] <= cfg_data_i;
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule

// File: design/cpu16_chk.sv
// Port checker for the 16-bit CPU core, bound to the top level.
module cpu16_chk (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input cpu16_pkg::out_t out_data_o
);
  import cpu16_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  a_kind_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_kind != 2'd3)
    else $error("bad print kind");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.out_kind != OUT_CHAR |-> out_data_o.out_char == 8'd0)
    else $error("character without print");

  a_no_print_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == RUN_KEY |-> out_data_o.out_kind == OUT_NONE)
    else $error("print on key stop");

endmodule

bind sixteen_bit_cpu_core_unit cpu16_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// File: tb/tb_sixteen_bit_cpu_core_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench of the 16-bit CPU core: program stream, interrupts, keys, prints.
module tb_sixteen_bit_cpu_core_unit;
  import cpu16_pkg::*;

  localparam int unsigned MEM_BYTES   = 4096;
  localparam int unsigned STACK_BYTES = 256;
  localparam int          ITEM_GOAL   = 1700;
  localparam int          QUIET_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  sixteen_bit_cpu_core_unit #(
    .MEM_BYTES  (MEM_BYTES),
    .STACK_BYTES(STACK_BYTES)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // machine state mirror
  logic [15:0] m_base, m_size, m_start;
  logic [15:0] gpr [8];
  logic [15:0] psw;
  logic [15:0] vec [8];
  bit          irq [8];
  logic [7:0]  img [MEM_BYTES];
  logic [7:0]  stk [STACK_BYTES];
  logic [15:0] calls;
  logic [7:0]  key_code;
  logic [1:0]  run_st;
  bit          begun, bad;
  logic [1:0]  okind;
  logic [7:0]  ochar;

  out_t result_q [$];
  int   errs = 0;
  int   n_sent = 0;
  int   n_exec = 0;
  int   n_print = 0;
  int   n_out = 0;
  bit   calm = 1'b0;
  int   hold_left = 0;

  function automatic void mirror_reset();
    m_base = '0; m_size = '0; m_start = '0;
    for (int k = 0; k < 8; k++) begin
      gpr[k] = '0; vec[k] = DFLT_VEC; irq[k] = 1'b0;
    end
    irq[0] = 1'b1;
    psw = PSW_INIT;
    for (int k = 0; k < MEM_BYTES; k++) img[k] = '0;
    for (int k = 0; k < STACK_BYTES; k++) stk[k] = '0;
    calls = '0; key_code = '0; run_st = RUN_OK;
    begun = 1'b0; bad = 1'b0; okind = OUT_NONE; ochar = '0;
  endfunction

  function automatic void mirror_cfg(logic [1:0] idx, logic [15:0] v);
    case (idx)
      CFG_BASE: m_base = v;
      CFG_SIZE: m_size = {3'b000, v[12:0]};
      CFG_START: begin
        m_start = v;
        if (!begun) gpr[R_PC] = v;
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned img_index(logic [15:0] a);
    int unsigned lim, off;
    lim = (m_size < MEM_BYTES) ? m_size : MEM_BYTES;
    if (a < m_base) begin
      bad = 1'b1; run_st = RUN_FAULT; return 0;
    end
    off = a - m_base;
    if (off + 1 >= lim) begin
      bad = 1'b1; run_st = RUN_FAULT; return 0;
    end
    return off;
  endfunction

  function automatic logic [15:0] rd_word(logic [15:0] a);
    int unsigned off;
    if (a == KEY_ADDR) return {8'h00, key_code};
    if (a == PUT_ADDR) return 16'h0000;
    if (a == DFLT_VEC) return DFLT_VAL;
    if (a < VEC_END) return vec[a[3:1]];
    off = img_index(a);
    if (bad) return 16'h0000;
    return {img[off+1], img[off]};
  endfunction

  function automatic void wr_word(logic [15:0] a, logic [15:0] v);
    int unsigned off;
    if (a == KEY_ADDR) return;
    if (a == PUT_ADDR) begin
      if (v == NEWLINE_CODE) begin
        okind = OUT_CRLF; ochar = '0;
      end else begin
        okind = OUT_CHAR; ochar = v[7:0];
      end
      return;
    end
    if (a < VEC_END) begin
      vec[a[3:1]] = v;
      return;
    end
    off = img_index(a);
    if (bad) return;
    img[off] = v[7:0];
    img[off+1] = v[15:8];
  endfunction

  function automatic void stk_put(logic [7:0] b);
    if (gpr[R_SP] >= STACK_BYTES) return;
    stk[gpr[R_SP]] = b;
    gpr[R_SP] = gpr[R_SP] + 16'd1;
  endfunction

  function automatic logic [7:0] stk_take();
    if (gpr[R_SP] == 0) return 8'h00;
    gpr[R_SP] = gpr[R_SP] - 16'd1;
    if (gpr[R_SP] >= STACK_BYTES) return 8'h00;
    return stk[gpr[R_SP]];
  endfunction

  function automatic void push16(logic [15:0] v);
    stk_put(v[15:8]);
    stk_put(v[7:0]);
  endfunction

  function automatic logic [15:0] pop16();
    logic [7:0] lo, hi;
    lo = stk_take();
    hi = stk_take();
    return {hi, lo};
  endfunction

  function automatic void flags_zn(logic [15:0] v);
    psw[0] = (v == 16'h0000);
    psw[3] = v[15];
  endfunction

  function automatic void put_dst(logic [1:0] dk, logic [2:0] dr, logic [15:0] ext,
                                  logic [15:0] v);
    case (dk)
      KIND_IMM: psw = v;
      KIND_REG: gpr[dr] = v;
      KIND_ABS: wr_word(ext, v);
      default:  wr_word(gpr[dr] + ext, v);
    endcase
  endfunction

  function automatic logic [15:0] get_opnd(logic [1:0] kd, logic [2:0] rg, logic [15:0] ext,
                                           bit is_src);
    case (kd)
      KIND_IMM: return (is_src && rg != 3'd7) ? ext : psw;
      KIND_REG: return gpr[rg];
      KIND_ABS: return rd_word(ext);
      default:  return rd_word(gpr[rg] + ext);
    endcase
  endfunction

  function automatic void run_instruction();
    logic [15:0] w, ext, sv, dv, rv;
    logic [31:0] wide;
    logic [1:0]  cc, dk, sk;
    logic [3:0]  op;
    logic [4:0]  dc, sc;
    bit          no_d, no_s, go;
    ext = '0; sv = '0; dv = '0;
    if (!begun) begin
      begun = 1'b1;
      gpr[R_PC] = m_start;
      if (m_start == 0) begin
        run_st = RUN_FAULT;
        return;
      end
    end
    for (int k = 0; k < 8; k++) begin
      if (psw[IRQ_ON_BIT] && irq[k] && !(k == 1 && !psw[TICK_ON_BIT])) begin
        push16(psw);
        push16(gpr[R_PC]);
        gpr[R_PC] = vec[k];
        irq[k] = 1'b0;
      end
    end
    w = rd_word(gpr[R_PC]);
    if (bad) return;
    gpr[R_PC] = gpr[R_PC] + 16'd2;
    w = {w[7:0], w[15:8]};
    cc = w[15:14]; op = w[13:10]; dc = w[9:5]; sc = w[4:0];
    dk = dc[4:3]; sk = sc[4:3];
    no_d = (op == OP_PUSH || op == OP_CALL || op == OP_IRET);
    no_s = (op == OP_POP || op == OP_IRET);
    if ((!no_d && dk != KIND_REG) || (!no_s && sk != KIND_REG)) begin
      ext = rd_word(gpr[R_PC]);
      if (bad) return;
      gpr[R_PC] = gpr[R_PC] + 16'd2;
    end
    case (cc)
      CC_Z:    go = psw[0];
      CC_NZ:   go = !psw[0];
      CC_GT:   go = !psw[0] && !psw[3];
      default: go = 1'b1;
    endcase
    if (!go) return;
    if (!no_s) begin
      sv = get_opnd(sk, sc[2:0], ext, 1'b1);
      if (bad) return;
    end
    if (!no_d) begin
      dv = get_opnd(dk, dc[2:0], ext, 1'b0);
      if (bad) return;
    end
    case (op)
      OP_ADD: begin
        wide = {16'h0, dv} + {16'h0, sv};
        rv = wide[15:0];
        put_dst(dk, dc[2:0], ext, rv);
        if (bad) return;
        flags_zn(rv);
        psw[1] = wide[16]; psw[2] = wide[16];
      end
      OP_SUB, OP_CMP: begin
        rv = dv - sv;
        if (op == OP_SUB) begin
          put_dst(dk, dc[2:0], ext, rv);
          if (bad) return;
        end
        flags_zn(rv);
        psw[1] = (dv < sv); psw[2] = (dv < sv);
      end
      OP_TEST: flags_zn(dv & sv);
      OP_PUSH: push16(sv);
      OP_POP: begin
        if (dc == {KIND_REG, R_PC}) begin
          if (calls == 0) begin
            run_st = RUN_DONE;
            return;
          end
          calls = calls - 16'd1;
        end
        rv = pop16();
        put_dst(dk, dc[2:0], ext, rv);
      end
      OP_CALL: begin
        calls = calls + 16'd1;
        push16(gpr[R_PC]);
        gpr[R_PC] = sv;
      end
      OP_IRET: begin
        gpr[R_PC] = pop16();
        psw = pop16();
      end
      OP_SHL: begin
        wide = (sv < 32) ? ({16'h0, dv} << sv) : 32'h0;
        rv = wide[15:0];
        put_dst(dk, dc[2:0], ext, rv);
        if (bad) return;
        flags_zn(rv);
        psw[2] = wide[16];
      end
      OP_SHR: begin
        rv = (sv < 16) ? (dv >> sv) : 16'h0;
        put_dst(dk, dc[2:0], ext, rv);
        if (bad) return;
        flags_zn(rv);
        psw[2] = 1'b0;
      end
      default: begin
        case (op)
          OP_MUL:  rv = dv * sv;
          OP_DIV:  rv = (sv != 0) ? dv / sv : 16'hFFFF;
          OP_AND:  rv = dv & sv;
          OP_OR:   rv = dv | sv;
          OP_NOT:  rv = ~sv;
          default: rv = sv;
        endcase
        put_dst(dk, dc[2:0], ext, rv);
        if (bad) return;
        flags_zn(rv);
      end
    endcase
  endfunction

  function automatic out_t apply_word(in_t w);
    okind = OUT_NONE; ochar = '0; bad = 1'b0;
    if (w.func == FUNC_LOAD) begin
      if (w.load_offset < MEM_BYTES) img[w.load_offset] = w.byte_value;
    end else if (run_st == RUN_OK) begin
      case (w.func)
        FUNC_EXEC: run_instruction();
        FUNC_KEY: begin
          key_code = w.byte_value;
          if (w.byte_value == KEY_STOP) run_st = RUN_KEY;
          else irq[2] = 1'b1;
        end
        default: irq[1] = 1'b1;
      endcase
    end
    return '{run_st, okind, ochar, gpr[R_PC], psw};
  endfunction

  // address of the next fetch, interrupts included
  function automatic logic [15:0] fetch_addr();
    logic [15:0] p;
    p = begun ? gpr[R_PC] : m_start;
    for (int k = 0; k < 8; k++)
      if (psw[IRQ_ON_BIT] && irq[k] && !(k == 1 && !psw[TICK_ON_BIT])) p = vec[k];
    return p;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] enc(logic [1:0] cc, logic [3:0] op, logic [4:0] dc,
                                      logic [4:0] sc);
    return {cc, op, dc, sc};
  endfunction

  function automatic logic [15:0] pick_imm();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom;
    if (r < 75) return $urandom_range(0, 40);
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'h0001;
      2: return 16'h7FFF;
      3: return 16'h8000;
      default: return 16'hFFFF;
    endcase
  endfunction

  function automatic logic [15:0] pick_pc();
    return 16'h0100 + 16'(2 * $urandom_range(0, 16'h0500));
  endfunction

  function automatic logic [15:0] pick_data();
    return 16'h0C00 + 16'($urandom_range(0, 254));
  endfunction

  function automatic logic [15:0] pick_addr(bit for_read);
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return pick_data();
    if (r < 80) return PUT_ADDR;
    if (r < 88) return KEY_ADDR;
    if (!for_read) return DFLT_VEC;
    return (r < 94) ? DFLT_VEC : 16'($urandom_range(0, 15));
  endfunction

  function automatic bit pc_ok(logic [15:0] p);
    return p >= 16'h0100 && p <= 16'h0B00;
  endfunction

  task automatic send(input in_t w, input bit typed = 1'b0, input out_t want = '0);
    out_t got;
    int g;
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    got = apply_word(w);
    result_q.push_back(typed ? want : got);
    n_sent++;
    if (w.func == FUNC_EXEC) n_exec++;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_exec();
    send('{FUNC_EXEC, 12'($urandom), 8'($urandom)});
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    mirror_cfg(idx, v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // run interrupt handlers at the fixed vector, at most 12, until a program fetch is next
  task automatic settle();
    logic [15:0] f;
    for (int i = 0; i < 12; i++) begin
      if (run_st != RUN_OK) return;
      f = fetch_addr();
      if (f != DFLT_VEC && f >= VEC_END) return;
      send_exec();
    end
  endtask

  // place one instruction at the fetch address and execute it
  task automatic place_and_run(input logic [15:0] f, input logic [15:0] w,
                               input logic [15:0] ext);
    if (f < 16'd4093) begin
      send('{FUNC_LOAD, f[11:0], w[15:8]});
      send('{FUNC_LOAD, 12'(f + 16'd1), w[7:0]});
      send('{FUNC_LOAD, 12'(f + 16'd2), ext[7:0]});
      send('{FUNC_LOAD, 12'(f + 16'd3), ext[15:8]});
    end
    send_exec();
  endtask

  task automatic run_instr(input logic [15:0] w, input logic [15:0] ext);
    settle();
    if (run_st == RUN_OK) place_and_run(fetch_addr(), w, ext);
  endtask

  task automatic random_step();
    logic [15:0] f, ext, sp, tgt;
    logic [1:0]  cc;
    logic [3:0]  op;
    logic [4:0]  dc, sc;
    logic [2:0]  rg;
    int          r;
    bit          clean, mem_used;
    settle();
    if (run_st != RUN_OK) return;
    f = fetch_addr();
    clean = (f == gpr[R_PC]);
    if (f > 16'h0BE0) begin
      place_and_run(f, enc(CC_ALL, OP_MOV, {KIND_REG, R_PC}, {KIND_IMM, 3'd0}), pick_pc());
      return;
    end
    cc = ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 2)) : CC_ALL;
    op = $urandom_range(0, 15);
    sp = gpr[R_SP];
    ext = pick_imm();
    mem_used = 1'b0;
    rg = $urandom_range(0, 5);
    r = $urandom_range(0, 99);
    if (r < 60) dc = {KIND_REG, rg};
    else if (r < 68) dc = {KIND_IMM, 3'($urandom_range(0, 7))};
    else if (r < 84) begin
      dc = {KIND_ABS, 3'($urandom)};
      ext = pick_addr(1'b0);
      mem_used = 1'b1;
    end else begin
      dc = {KIND_IDX, rg};
      ext = pick_data() - gpr[rg];
      mem_used = 1'b1;
    end
    rg = $urandom_range(0, 5);
    r = $urandom_range(0, 99);
    if (r < 40) sc = {KIND_IMM, 3'($urandom_range(0, 6))};
    else if (r < 70 || (r >= 78 && mem_used)) sc = {KIND_REG, 3'($urandom_range(0, 7))};
    else if (r < 78) sc = {KIND_IMM, 3'd7};
    else if (r < 89) begin
      sc = {KIND_ABS, 3'($urandom)};
      ext = pick_addr(1'b1);
    end else begin
      sc = {KIND_IDX, rg};
      ext = pick_data() - gpr[rg];
    end
    if (op == OP_CALL) begin
      sc = {KIND_IMM, 3'd0};
      ext = pick_pc();
    end
    if (op == OP_POP && clean && calls != 0 && sp >= 2 && sp <= STACK_BYTES &&
        $urandom_range(0, 3) == 0) begin
      tgt = {stk[sp-2], stk[sp-1]};
      if (pc_ok(tgt)) dc = {KIND_REG, R_PC};
    end
    if (op == OP_IRET) begin
      tgt = (sp >= 4 && sp <= STACK_BYTES) ? {stk[sp-2], stk[sp-1]} : 16'h0;
      if (!(clean && pc_ok(tgt))) op = OP_MOV;
    end
    place_and_run(f, enc(cc, op, dc, sc), ext);
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_out++;
      if (out_data_o.out_kind != OUT_NONE) n_print++;
      if (result_q.size() == 0) begin
        if (errs < 10) $display("tb: unexpected word %h", out_data_o);
        errs++;
      end else begin
        want = result_q.pop_front();
        if (out_data_o.status != want.status || out_data_o.out_kind != want.out_kind ||
            out_data_o.out_char != want.out_char || out_data_o.pc_now != want.pc_now ||
            out_data_o.psw_now != want.psw_now) begin
          if (errs < 10)
            $display("tb: mismatch status %0d/%0d kind %0d/%0d char %h/%h pc %h/%h psw %h/%h",
                     want.status, out_data_o.status, want.out_kind, out_data_o.out_kind,
                     want.out_char, out_data_o.out_char, want.pc_now, out_data_o.pc_now,
                     want.psw_now, out_data_o.psw_now);
          errs++;
        end
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  always @(posedge clk_i) begin
    int   seg_left;
    logic seg_stall;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left <= 0) begin
        seg_stall = !calm && ($urandom_range(0, 99) < 35);
        seg_left = gap_len() + 1;
      end
      seg_left = seg_left - 1;
      out_stall_i <= seg_stall;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    int quiet;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb: watchdog expired, %0d words outstanding", result_q.size());
      $display("tb: failure");
      $finish;
    end
  end

  typedef struct {
    logic [1:0]  func;
    logic [15:0] a;
    logic [15:0] b;
    bit          typed;
  } row_t;

  function automatic row_t ins(logic [15:0] w, logic [15:0] ext);
    return '{FUNC_EXEC, w, ext, 1'b0};
  endfunction

  initial begin
    row_t  plan [$];
    out_t  at_start;
    logic [4:0] r0, r1, r2, r3, r4, r5, imm;
    mirror_reset();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes first, then the working setup
    cfg_write(CFG_BASE, 16'hFFFF);
    cfg_write(CFG_SIZE, 16'h0000);
    cfg_write(CFG_START, 16'hFFFF);
    cfg_write(CFG_SIZE, 16'h1000);
    cfg_write(CFG_BASE, 16'h0000);
    cfg_write(CFG_START, 16'h0100);

    r0 = {KIND_REG, 3'd0}; r1 = {KIND_REG, 3'd1}; r2 = {KIND_REG, 3'd2};
    r3 = {KIND_REG, 3'd3}; r4 = {KIND_REG, 3'd4}; r5 = {KIND_REG, 3'd5};
    imm = {KIND_IMM, 3'd0};
    at_start = '{RUN_OK, OUT_NONE, 8'h00, 16'h0100, PSW_INIT};
    plan.push_back('{FUNC_TICK, 16'h0, 16'h0, 1'b1});
    plan.push_back('{FUNC_KEY, 16'h0, 16'h0041, 1'b1});
    plan.push_back('{FUNC_LOAD, 16'h0FFF, 16'h00FF, 1'b1});
    plan.push_back('{FUNC_LOAD, 16'h0000, 16'h0000, 1'b1});
    plan.push_back(ins(enc(CC_ALL, OP_MOV, r5, imm), DFLT_VEC));
    plan.push_back(ins(enc(CC_ALL, OP_MOV, {KIND_ABS, 3'd0}, r5), 16'h0002));
    plan.push_back(ins(enc(CC_ALL, OP_ADD, r0, imm), 16'hFFFF));
    plan.push_back(ins(enc(CC_ALL, OP_ADD, r0, imm), 16'h0001));
    plan.push_back(ins(enc(CC_ALL, OP_SUB, r1, imm), 16'h0001));
    plan.push_back(ins(enc(CC_ALL, OP_MUL, r1, imm), 16'h0003));
    plan.push_back(ins(enc(CC_ALL, OP_DIV, r1, imm), 16'h0000));
    plan.push_back(ins(enc(CC_ALL, OP_CMP, r1, imm), 16'h8000));
    plan.push_back(ins(enc(CC_ALL, OP_AND, r1, imm), 16'h00FF));
    plan.push_back(ins(enc(CC_ALL, OP_OR, r2, imm), 16'h8000));
    plan.push_back(ins(enc(CC_ALL, OP_NOT, r3, imm), 16'h5555));
    plan.push_back(ins(enc(CC_ALL, OP_TEST, r2, imm), 16'h8000));
    plan.push_back(ins(enc(CC_ALL, OP_SHL, r2, imm), 16'h0001));
    plan.push_back(ins(enc(CC_ALL, OP_SHL, r1, imm), 16'd40));
    plan.push_back(ins(enc(CC_ALL, OP_SHR, r3, imm), 16'd16));
    plan.push_back(ins(enc(CC_ALL, OP_MOV, r4, imm), NEWLINE_CODE));
    plan.push_back(ins(enc(CC_ALL, OP_MOV, {KIND_ABS, 3'd0}, r4), PUT_ADDR));
    plan.push_back(ins(enc(CC_ALL, OP_MOV, r4, {KIND_ABS, 3'd0}), KEY_ADDR));
    plan.push_back(ins(enc(CC_ALL, OP_MOV, {KIND_IDX, 3'd5}, r4), 16'h0C10 - DFLT_VEC));
    plan.push_back(ins(enc(CC_ALL, OP_PUSH, r0, {KIND_IMM, 3'd7}), 16'h0));
    plan.push_back(ins(enc(CC_ALL, OP_POP, r3, r0), 16'h0));
    plan.push_back(ins(enc(CC_ALL, OP_CALL, r0, imm), 16'h0300));
    plan.push_back(ins(enc(CC_ALL, OP_POP, {KIND_REG, R_PC}, r0), 16'h0));
    plan.push_back(ins(enc(CC_ALL, OP_MOV, imm, imm), 16'hA009));
    plan.push_back(ins(enc(CC_GT, OP_ADD, r0, imm), 16'h0005));
    plan.push_back(ins(enc(CC_Z, OP_ADD, r0, imm), 16'h0007));

    foreach (plan[i]) begin
      if (plan[i].func == FUNC_EXEC)
        run_instr(plan[i].a, plan[i].b);
      else
        send('{plan[i].func, plan[i].a[11:0], plan[i].b[7:0]}, plan[i].typed, at_start);
    end
    drain();
    cfg_write(CFG_SIZE, 16'h0D00);
    cfg_write(CFG_START, 16'h0000);

    while (n_sent < ITEM_GOAL && run_st == RUN_OK) begin
      if (n_sent % 300 < 40) calm = 1'b1;
      else calm = 1'b0;
      if (n_sent >= 500 && n_sent < 506 && hold_left == 0) hold_left = 300;
      if (n_sent >= 900 && n_sent < 906) begin
        drain();
        cfg_write(CFG_SIZE, 16'h1000);
        cfg_write(CFG_BASE, 16'h0000);
      end
      case ($urandom_range(0, 19))
        0: send('{FUNC_KEY, 12'($urandom), 8'($urandom_range(4, 255))});
        1: send('{FUNC_TICK, 12'($urandom), 8'($urandom)});
        2: send('{FUNC_LOAD, 12'($urandom), 8'($urandom)});
        default: random_step();
      endcase
    end
    calm = 1'b0;

    // end the program once, then show that nothing but loads acts any more
    settle();
    case ($urandom_range(0, 2))
      0: send('{FUNC_KEY, 12'h000, KEY_STOP});
      1: begin
        if (calls == 0) run_instr(enc(CC_ALL, OP_POP, {KIND_REG, R_PC}, r0), 16'h0);
        else send('{FUNC_KEY, 12'h000, KEY_STOP});
      end
      default: run_instr(enc(CC_ALL, OP_MOV, r0, {KIND_ABS, 3'd0}), 16'h0FFF);
    endcase
    send_exec();
    send('{FUNC_KEY, 12'hFFF, 8'h55});
    send('{FUNC_TICK, 12'h000, 8'h00});
    send('{FUNC_LOAD, 12'h010, 8'hAA});
    drain();
    repeat (20) @(posedge clk_i);

    $display("tb: %0d words sent, %0d executes, %0d results, %0d printed",
             n_sent, n_exec, n_out, n_print);
    $display("tb: final status %0d, %0d mismatches", run_st, errs);
    if (errs == 0 && result_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sixteen_bit_cpu_core_unit.f
design/cpu16_pkg.sv
design/cpu16_ram.sv
design/cpu16_div.sv
design/sixteen_bit_cpu_core_unit.sv
design/cpu16_chk.sv
tb/tb_sixteen_bit_cpu_core_unit.sv
